// ----- rtl/tte_pkg.sv -----
// Shared constants, types and tables for the track transform extractor.
package tte_pkg;

    // Fixed-point format and iteration counts
    localparam int FRAC_BITS    = 16;
    localparam int ANGLE_BITS   = 30;
    localparam int PRE_SHIFT    = 24;
    localparam int CORDIC_STEPS = 31;
    localparam int CHAIN_LEN    = 32;
    localparam int STEP_W       = 5;
    localparam int SQ_TOP       = 62;
    localparam int DSR_W        = 35;
    localparam int ROUND_SHIFT  = ANGLE_BITS - FRAC_BITS;

    // Binding targets
    localparam logic [1:0] TGT_POS    = 2'd0;
    localparam logic [1:0] TGT_ROT    = 2'd1;
    localparam logic [1:0] TGT_SCALE  = 2'd2;
    localparam logic [1:0] TGT_CORNER = 2'd3;

    // Register indexes
    localparam logic [1:0] REG_TARGET = 2'd0;
    localparam logic [1:0] REG_LIMIT  = 2'd1;

    // Operation carried by a slot through the chain
    localparam logic [1:0] OP_PASS = 2'd0;
    localparam logic [1:0] OP_ROT  = 2'd1;
    localparam logic [1:0] OP_SQRT = 2'd2;
    localparam logic [1:0] OP_DIV  = 2'd3;

    localparam logic [1:0] CORNER_LAST = 2'd3;

    // Angles in Q2.30
    localparam logic signed [63:0] PI_Q30  = 64'sd3373259426;
    localparam logic signed [63:0] PI_OUT  =
        (PI_Q30 + (64'sd1 <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;

    localparam logic [31:0] ATAN_TAB [0:CHAIN_LEN-1] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
        32'd67021687, 32'd33543516, 32'd16775851, 32'd8388437,
        32'd4194283, 32'd2097149, 32'd1048576, 32'd524288,
        32'd262144, 32'd131072, 32'd65536, 32'd32768,
        32'd16384, 32'd8192, 32'd4096, 32'd2048,
        32'd1024, 32'd512, 32'd256, 32'd128,
        32'd64, 32'd32, 32'd16, 32'd8,
        32'd4, 32'd2, 32'd1, 32'd0
    };

    // One accepted input item
    typedef struct packed {
        logic [1:0]       pres;
        logic [31:0]      pos_x;
        logic [31:0]      pos_y;
        logic [8:0][31:0] m;
    } item_t;

    // One unit of work moving down the chain
    typedef struct packed {
        logic [1:0]       op;
        logic             written;
        logic [1:0]       corner;
        logic             last;
        logic [63:0]      l0_rem;
        logic [63:0]      l0_acc;
        logic [63:0]      l1_rem;
        logic [63:0]      l1_acc;
        logic [DSR_W-1:0] dsr;
        logic             ovf0;
        logic             ovf1;
        logic             neg0;
        logic             neg1;
    } slot_t;

endpackage

// ----- rtl/tte_cell.sv -----
// One chain cell: a single CORDIC, square-root or division step, or a pass-through, registered.
module tte_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         advance,
    input  logic [tte_pkg::STEP_W-1:0]   step,
    input  logic                         in_valid,
    input  tte_pkg::slot_t               in_slot,
    output logic                         out_valid,
    output tte_pkg::slot_t               out_slot
);

    logic           valid_reg;
    tte_pkg::slot_t slot_reg;
    tte_pkg::slot_t slot_next;

    // Compute one step of whatever the slot carries
    always_comb
    begin
        logic signed [63:0] cx;
        logic signed [63:0] cy;
        logic signed [63:0] cz;
        logic signed [63:0] dx;
        logic signed [63:0] dy;
        logic signed [63:0] at;
        logic [63:0]        sbit;
        logic [63:0]        t0;
        logic [63:0]        t1;
        logic [63:0]        q0;
        logic [63:0]        q1;
        logic [63:0]        dv;

        cx   = $signed(in_slot.l0_rem);
        cy   = $signed(in_slot.l1_rem);
        cz   = $signed(in_slot.l0_acc);
        dx   = cy >>> step;
        dy   = cx >>> step;
        at   = $signed({32'b0, tte_pkg::ATAN_TAB[step]});
        sbit = 64'd1 << (6'(tte_pkg::SQ_TOP) - {step, 1'b0});
        t0   = in_slot.l0_acc + sbit;
        t1   = in_slot.l1_acc + sbit;
        q0   = {in_slot.l0_rem[62:0], in_slot.l0_acc[31]};
        q1   = {in_slot.l1_rem[62:0], in_slot.l1_acc[31]};
        dv   = 64'(in_slot.dsr);

        slot_next = in_slot;
        unique case (in_slot.op)
            tte_pkg::OP_PASS:
            begin
                slot_next = in_slot;
            end
            tte_pkg::OP_ROT:
            begin
                // Rotate toward the x axis
                if (step < (tte_pkg::STEP_W)'(tte_pkg::CORDIC_STEPS))
                begin
                    if (cy > 64'sd0)
                    begin
                        slot_next.l0_rem = cx + dx;
                        slot_next.l1_rem = cy - dy;
                        slot_next.l0_acc = cz + at;
                    end
                    else
                    begin
                        slot_next.l0_rem = cx - dx;
                        slot_next.l1_rem = cy + dy;
                        slot_next.l0_acc = cz - at;
                    end
                end
            end
            tte_pkg::OP_SQRT:
            begin
                // Resolve one root bit per lane
                if (in_slot.l0_rem >= t0)
                begin
                    slot_next.l0_rem = in_slot.l0_rem - t0;
                    slot_next.l0_acc = (in_slot.l0_acc >> 1) + sbit;
                end
                else
                begin
                    slot_next.l0_acc = in_slot.l0_acc >> 1;
                end
                if (in_slot.l1_rem >= t1)
                begin
                    slot_next.l1_rem = in_slot.l1_rem - t1;
                    slot_next.l1_acc = (in_slot.l1_acc >> 1) + sbit;
                end
                else
                begin
                    slot_next.l1_acc = in_slot.l1_acc >> 1;
                end
            end
            tte_pkg::OP_DIV:
            begin
                // Resolve one quotient bit per lane
                if (q0 >= dv)
                begin
                    slot_next.l0_rem = q0 - dv;
                    slot_next.l0_acc = {32'b0, in_slot.l0_acc[30:0], 1'b1};
                end
                else
                begin
                    slot_next.l0_rem = q0;
                    slot_next.l0_acc = {32'b0, in_slot.l0_acc[30:0], 1'b0};
                end
                if (q1 >= dv)
                begin
                    slot_next.l1_rem = q1 - dv;
                    slot_next.l1_acc = {32'b0, in_slot.l1_acc[30:0], 1'b1};
                end
                else
                begin
                    slot_next.l1_rem = q1;
                    slot_next.l1_acc = {32'b0, in_slot.l1_acc[30:0], 1'b0};
                end
            end
        endcase
    end

    // Advance the valid flag with the chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    // Hold payload while the chain stalls
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            slot_reg <= slot_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_slot  = slot_reg;

endmodule

// ----- rtl/tte_prep.sv -----
// Setup logic: turns an item and corner index into the slot entering the chain.
module tte_prep (
    input  tte_pkg::item_t  item,
    input  logic [1:0]      cnt,
    input  logic [1:0]      target,
    input  logic [15:0]     limit,
    output tte_pkg::slot_t  slot
);

    always_comb
    begin
        logic               missing;
        logic signed [63:0] rx;
        logic signed [63:0] ry;
        logic signed [63:0] rz;
        logic [31:0]        a0;
        logic [31:0]        a1;
        logic [31:0]        a3;
        logic [31:0]        a4;
        logic               ux;
        logic               uy;
        logic signed [34:0] nx;
        logic signed [34:0] ny;
        logic signed [34:0] w;
        logic signed [34:0] aw;
        logic signed [34:0] anx;
        logic signed [34:0] any_n;
        logic [tte_pkg::DSR_W-1:0] dsr;
        logic               wneg;
        logic [63:0]        dnx;
        logic [63:0]        dny;

        missing = !item.pres[0] || (target != tte_pkg::TGT_POS && !item.pres[1]);

        // Rotation start vector, turned by pi when x is negative
        rx = $signed({{32{item.m[0][31]}}, item.m[0]}) <<< tte_pkg::PRE_SHIFT;
        ry = $signed({{32{item.m[3][31]}}, item.m[3]}) <<< tte_pkg::PRE_SHIFT;
        rz = 64'sd0;
        if (rx < 64'sd0)
        begin
            rz = (ry >= 64'sd0) ? tte_pkg::PI_Q30 : -tte_pkg::PI_Q30;
            rx = -rx;
            ry = -ry;
        end

        // Magnitudes for the column lengths
        a0 = item.m[0][31] ? 32'(-item.m[0]) : item.m[0];
        a1 = item.m[1][31] ? 32'(-item.m[1]) : item.m[1];
        a3 = item.m[3][31] ? 32'(-item.m[3]) : item.m[3];
        a4 = item.m[4][31] ? 32'(-item.m[4]) : item.m[4];

        // Homography sums for this corner
        ux = (cnt == 2'd1) || (cnt == 2'd2);
        uy = cnt[1];
        nx = (ux ? 35'($signed(item.m[0])) : 35'sd0)
           + (uy ? 35'($signed(item.m[1])) : 35'sd0) + 35'($signed(item.m[2]));
        ny = (ux ? 35'($signed(item.m[3])) : 35'sd0)
           + (uy ? 35'($signed(item.m[4])) : 35'sd0) + 35'($signed(item.m[5]));
        w  = (ux ? 35'($signed(item.m[6])) : 35'sd0)
           + (uy ? 35'($signed(item.m[7])) : 35'sd0) + 35'($signed(item.m[8]));
        aw    = (w < 35'sd0) ? -w : w;
        anx   = (nx < 35'sd0) ? -nx : nx;
        any_n = (ny < 35'sd0) ? -ny : ny;

        // Replace a near-zero w by one
        if (w == 35'sd0 || $unsigned(aw) < 35'(limit))
        begin
            dsr  = tte_pkg::DSR_W'(1) << tte_pkg::FRAC_BITS;
            wneg = 1'b0;
        end
        else
        begin
            dsr  = $unsigned(aw);
            wneg = w < 35'sd0;
        end
        dnx = 64'($unsigned(anx)) << tte_pkg::FRAC_BITS;
        dny = 64'($unsigned(any_n)) << tte_pkg::FRAC_BITS;

        slot         = '0;
        slot.op      = tte_pkg::OP_PASS;
        slot.written = 1'b1;
        slot.last    = 1'b1;
        if (missing)
        begin
            slot.written = 1'b0;
        end
        else
        begin
            unique case (target)
                tte_pkg::TGT_POS:
                begin
                    slot.l0_rem = {32'b0, item.pos_x};
                    slot.l1_rem = {32'b0, item.pos_y};
                end
                tte_pkg::TGT_ROT:
                begin
                    if (item.m[3] == 32'd0)
                    begin
                        slot.l0_rem = item.m[0][31] ? tte_pkg::PI_OUT : 64'd0;
                    end
                    else
                    begin
                        slot.op     = tte_pkg::OP_ROT;
                        slot.l0_rem = rx;
                        slot.l1_rem = ry;
                        slot.l0_acc = rz;
                    end
                end
                tte_pkg::TGT_SCALE:
                begin
                    slot.op     = tte_pkg::OP_SQRT;
                    slot.l0_rem = (64'(a0) * 64'(a0)) + (64'(a3) * 64'(a3));
                    slot.l1_rem = (64'(a1) * 64'(a1)) + (64'(a4) * 64'(a4));
                end
                tte_pkg::TGT_CORNER:
                begin
                    slot.op     = tte_pkg::OP_DIV;
                    slot.corner = cnt;
                    slot.last   = (cnt == tte_pkg::CORNER_LAST);
                    slot.dsr    = dsr;
                    slot.l0_rem = {32'b0, dnx[63:32]};
                    slot.l0_acc = {32'b0, dnx[31:0]};
                    slot.l1_rem = {32'b0, dny[63:32]};
                    slot.l1_acc = {32'b0, dny[31:0]};
                    slot.ovf0   = 35'(dnx[63:32]) >= dsr;
                    slot.ovf1   = 35'(dny[63:32]) >= dsr;
                    slot.neg0   = (nx < 35'sd0) ^ wneg;
                    slot.neg1   = (ny < 35'sd0) ^ wneg;
                end
            endcase
        end
    end

endmodule

// ----- rtl/tte_finish.sv -----
// Final rounding and saturation of a slot leaving the chain.
module tte_finish (
    input  tte_pkg::slot_t slot,
    output logic [31:0]    first,
    output logic [31:0]    second
);

    // Clamp a signed value to the 32-bit range
    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        logic [31:0] r;
        if (v > 64'sd2147483647)
        begin
            r = 32'h7FFF_FFFF;
        end
        else if (v < -64'sd2147483648)
        begin
            r = 32'h8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Apply the sign and limit to a quotient
    function automatic logic [31:0] quot(input logic [31:0] q, input logic ovf,
                                         input logic neg);
        logic [31:0] r;
        if (neg)
        begin
            r = (ovf || q > 32'h8000_0000) ? 32'h8000_0000 : 32'(-q);
        end
        else
        begin
            r = (ovf || q[31]) ? 32'h7FFF_FFFF : q;
        end
        return r;
    endfunction

    // Round a root to nearest and limit it
    function automatic logic [31:0] root(input logic [63:0] rem, input logic [63:0] r);
        logic [63:0] v;
        v = r + ((rem > r) ? 64'd1 : 64'd0);
        return (v > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : v[31:0];
    endfunction

    always_comb
    begin
        logic signed [63:0] zr;
        zr = ($signed(slot.l0_acc) + (64'sd1 <<< (tte_pkg::ROUND_SHIFT - 1)))
             >>> tte_pkg::ROUND_SHIFT;
        unique case (slot.op)
            tte_pkg::OP_PASS:
            begin
                first  = slot.l0_rem[31:0];
                second = slot.l1_rem[31:0];
            end
            tte_pkg::OP_ROT:
            begin
                first  = sat32(zr);
                second = 32'd0;
            end
            tte_pkg::OP_SQRT:
            begin
                first  = root(slot.l0_rem, slot.l0_acc);
                second = root(slot.l1_rem, slot.l1_acc);
            end
            tte_pkg::OP_DIV:
            begin
                first  = quot(slot.l0_acc[31:0], slot.ovf0, slot.neg0);
                second = quot(slot.l1_acc[31:0], slot.ovf1, slot.neg1);
            end
        endcase
    end

endmodule

// ----- rtl/track_transform_extractor.sv -----
// Top level: issue stage, setup stage, 32-cell step chain and output register.
// An accepted item goes through the issue, setup, chain cell and output registers in that order.
// Throughput: one item per cycle in position, rotation and scale modes unless the output stalls;
// corner pin issues one slot per corner, four per complete item, before it takes a new item.
// The whole chain moves together; it holds while a result waits at the output.
// Reset clears all valid flags and sets binding_target 0, near_zero_limit 1.
module track_transform_extractor (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         present,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] m0,
    input  logic signed [31:0] m1,
    input  logic signed [31:0] m2,
    input  logic signed [31:0] m3,
    input  logic signed [31:0] m4,
    input  logic signed [31:0] m5,
    input  logic signed [31:0] m6,
    input  logic signed [31:0] m7,
    input  logic signed [31:0] m8,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               written,
    output logic signed [31:0] first_value,
    output logic signed [31:0] second_value,
    output logic [1:0]         corner,
    output logic               last
);

    logic [1:0]          target_reg;
    logic [15:0]         limit_reg;
    logic                issue_valid_reg;
    logic                issue_multi_reg;
    logic [1:0]          issue_cnt_reg;
    tte_pkg::item_t      issue_item_reg;
    logic                prep_valid_reg;
    tte_pkg::slot_t      prep_slot_reg;
    tte_pkg::slot_t      prep_slot;
    logic                advance;
    logic                issue_done;
    logic                accept;
    logic                cell_valid [0:tte_pkg::CHAIN_LEN];
    tte_pkg::slot_t      cell_slot [0:tte_pkg::CHAIN_LEN];
    logic [31:0]         fin_first;
    logic [31:0]         fin_second;
    logic                out_valid_reg;
    logic                written_reg;
    logic [31:0]         first_reg;
    logic [31:0]         second_reg;
    logic [1:0]          corner_reg;
    logic                last_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= tte_pkg::TGT_POS;
            limit_reg  <= 16'd1;
        end
        else if (cfg_we)
        begin
            if (cfg_index == tte_pkg::REG_TARGET)
            begin
                target_reg <= cfg_data[1:0];
            end
            else if (cfg_index == tte_pkg::REG_LIMIT)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    // Handshake control
    assign advance    = !out_valid_reg || !out_stall;
    assign issue_done = advance &&
                        (!issue_multi_reg || issue_cnt_reg == tte_pkg::CORNER_LAST);
    assign in_stall   = issue_valid_reg && !issue_done;
    assign accept     = in_valid && !in_stall;

    // Issue stage: hold the item while its slots go out
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_valid_reg <= 1'b0;
            issue_multi_reg <= 1'b0;
            issue_cnt_reg   <= 2'd0;
        end
        else if (accept)
        begin
            issue_valid_reg <= 1'b1;
            issue_multi_reg <= (target_reg == tte_pkg::TGT_CORNER) && (present == 2'd3);
            issue_cnt_reg   <= 2'd0;
        end
        else if (issue_valid_reg && advance)
        begin
            if (issue_done)
            begin
                issue_valid_reg <= 1'b0;
            end
            else
            begin
                issue_cnt_reg <= issue_cnt_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            issue_item_reg.pres  <= present;
            issue_item_reg.pos_x <= pos_x;
            issue_item_reg.pos_y <= pos_y;
            issue_item_reg.m     <= {m8, m7, m6, m5, m4, m3, m2, m1, m0};
        end
    end

    // Setup stage
    tte_prep u_prep (
        .item   (issue_item_reg),
        .cnt    (issue_cnt_reg),
        .target (target_reg),
        .limit  (limit_reg),
        .slot   (prep_slot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            prep_valid_reg <= issue_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prep_slot_reg <= prep_slot;
        end
    end

    // Step chain
    assign cell_valid[0] = prep_valid_reg;
    assign cell_slot[0]  = prep_slot_reg;

    for (genvar g = 0; g < tte_pkg::CHAIN_LEN; g++)
    begin : g_cell
        tte_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .step      ((tte_pkg::STEP_W)'(g)),
            .in_valid  (cell_valid[g]),
            .in_slot   (cell_slot[g]),
            .out_valid (cell_valid[g+1]),
            .out_slot  (cell_slot[g+1])
        );
    end

    // Rounding and saturation
    tte_finish u_finish (
        .slot   (cell_slot[tte_pkg::CHAIN_LEN]),
        .first  (fin_first),
        .second (fin_second)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= cell_valid[tte_pkg::CHAIN_LEN];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            written_reg <= cell_slot[tte_pkg::CHAIN_LEN].written;
            first_reg   <= fin_first;
            second_reg  <= fin_second;
            corner_reg  <= cell_slot[tte_pkg::CHAIN_LEN].corner;
            last_reg    <= cell_slot[tte_pkg::CHAIN_LEN].last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign written      = written_reg;
    assign first_value  = $signed(first_reg);
    assign second_value = $signed(second_reg);
    assign corner       = corner_reg;
    assign last         = last_reg;

`ifndef ASSERT_OFF
    a_idle_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !issue_valid_reg |-> !in_stall)
        else $error("input stalled with an empty issue stage");

    a_mid_written: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> written)
        else $error("non-final result without an update");

    a_corner_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=>
        out_valid && corner == $past(corner) + 2'd1)
        else $error("corner results out of order");

    a_corner_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !written |-> corner == 2'd0 && last)
        else $error("missing-data result with corner set");
`endif

endmodule
